// ===== design/rtip_pkg.sv =====
// Shared types, constants and helpers for the radix text-to-integer parser.
`default_nettype none
package rtip_pkg;

	localparam int MAX_LEN_DEF = 255;

	localparam int CHAR_W   = 8;
	localparam int RADIX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int OFFSET_W = 8;
	localparam int CFG_W    = 6;
	localparam int OUT_W    = 48;

	localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
	localparam logic               SIGNED_RESET = 1'b1;

	// Configuration register indexes.
	localparam logic CFG_RADIX  = 1'b0;
	localparam logic CFG_SIGNED = 1'b1;

	localparam logic [VALUE_W-1:0] SIGNED_MAX   = 32'h7FFF_FFFF;
	localparam logic [VALUE_W-1:0] SIGNED_MIN   = 32'h8000_0000;
	localparam logic [VALUE_W-1:0] UNSIGNED_MAX = 32'hFFFF_FFFF;
	localparam logic [CHAR_W-1:0]  NO_DIGIT     = 8'd255;

	typedef enum logic [2:0] {
		PH_SKIP,
		PH_SIGNED,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		phase_t               phase;
		logic [VALUE_W-1:0]   acc;
		logic                 neg;
		logic                 ovf;
		logic                 dig;
		logic [RADIX_W-1:0]   base;
		logic [OFFSET_W-1:0]  stop;
	} state_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] offset;
		logic                ovf;
		logic                found;
	} result_t;

	localparam state_t STATE_CLEAR = '{
		phase: PH_SKIP,
		acc:   '0,
		neg:   1'b0,
		ovf:   1'b0,
		dig:   1'b0,
		base:  '0,
		stop:  '0
	};

	// Value of a digit or letter, or NO_DIGIT for any other character.
	function automatic logic [CHAR_W-1:0] digit_value(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] d;
		d = NO_DIGIT;
		if (c >= "0" && c <= "9") begin
			d = c - 8'd48;
		end else if (c >= "A" && c <= "Z") begin
			d = c - 8'd55;
		end else if (c >= "a" && c <= "z") begin
			d = c - 8'd87;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== design/rtip_step.sv =====
// Next-state and result logic for one character of the parser.
`default_nettype none
module rtip_step #(
	parameter int MAX_LEN = rtip_pkg::MAX_LEN_DEF,
	parameter int POS_W   = $clog2(MAX_LEN + 1)
) (
	input  wire rtip_pkg::state_t             cur,
	input  wire logic [POS_W-1:0]             pos,
	input  wire logic [rtip_pkg::CHAR_W-1:0]  char_code,
	input  wire logic                         string_end,
	input  wire logic [rtip_pkg::RADIX_W-1:0] radix_select,
	input  wire logic                         signed_mode,
	output rtip_pkg::state_t                  nxt,
	output logic [POS_W-1:0]                  nxt_pos,
	output rtip_pkg::result_t                 res
);

	rtip_pkg::state_t               st;
	logic [rtip_pkg::RADIX_W-1:0]   b;
	logic [rtip_pkg::RADIX_W-1:0]   take_base;
	logic                           do_take;
	logic                           is_space;
	logic                           zero_start;
	logic [rtip_pkg::CHAR_W-1:0]    d;
	logic [38:0]                    next_val;
	logic [38:0]                    limit;
	logic [16:0]                    p_inc;
	logic [rtip_pkg::OFFSET_W-1:0]  off_next;

	always_comb begin
		p_inc    = 17'(pos) + 17'd1;
		off_next = (p_inc > 17'd255) ? 8'd255 : p_inc[7:0];
		is_space = (char_code == " ") || (char_code >= 8'd9 && char_code <= 8'd13);
		d        = rtip_pkg::digit_value(char_code);

		st         = cur;
		do_take    = 1'b0;
		zero_start = 1'b0;
		take_base  = cur.base;
		b          = cur.base;

		unique case (cur.phase)
			rtip_pkg::PH_SKIP, rtip_pkg::PH_SIGNED: begin
				if (cur.phase == rtip_pkg::PH_SKIP) begin
					b = radix_select;
				end
				if (cur.phase == rtip_pkg::PH_SKIP && is_space) begin
					st = cur;
				end else if (cur.phase == rtip_pkg::PH_SKIP && char_code == "-") begin
					st.base  = b;
					st.neg   = 1'b1;
					st.phase = rtip_pkg::PH_SIGNED;
				end else if (cur.phase == rtip_pkg::PH_SKIP && char_code == "+") begin
					st.base  = b;
					st.phase = rtip_pkg::PH_SIGNED;
				end else begin
					zero_start = (char_code == "0") &&
						(b == 6'd0 || b == 6'd16 || b == 6'd2);
					if (zero_start) begin
						st.base  = b;
						st.phase = rtip_pkg::PH_ZERO;
						st.dig   = 1'b1;
						st.stop  = off_next;
					end else begin
						take_base = (b == 6'd0) ? 6'd10 : b;
						st.base   = take_base;
						st.phase  = rtip_pkg::PH_DIGITS;
						do_take   = 1'b1;
					end
				end
			end
			rtip_pkg::PH_ZERO: begin
				if ((char_code == "x" || char_code == "X") &&
						(cur.base == 6'd0 || cur.base == 6'd16)) begin
					st.base  = 6'd16;
					st.dig   = 1'b0;
					st.stop  = '0;
					st.phase = rtip_pkg::PH_DIGITS;
				end else if ((char_code == "b" || char_code == "B") &&
						(cur.base == 6'd0 || cur.base == 6'd2)) begin
					st.base  = 6'd2;
					st.dig   = 1'b0;
					st.stop  = '0;
					st.phase = rtip_pkg::PH_DIGITS;
				end else begin
					take_base = (cur.base == 6'd0) ? 6'd8 : cur.base;
					st.base   = take_base;
					st.phase  = rtip_pkg::PH_DIGITS;
					do_take   = 1'b1;
				end
			end
			rtip_pkg::PH_DIGITS: begin
				do_take = 1'b1;
			end
			default: begin
				st = cur;
			end
		endcase

		// One multiply-add serves every path that consumes a digit.
		next_val = {7'd0, cur.acc} * {33'd0, take_base} + {31'd0, d};
		if (signed_mode) begin
			limit = cur.neg ? {7'd0, rtip_pkg::SIGNED_MIN} : {7'd0, rtip_pkg::SIGNED_MAX};
		end else begin
			limit = {7'd0, rtip_pkg::UNSIGNED_MAX};
		end

		if (do_take) begin
			if (d >= {2'd0, take_base}) begin
				st.phase = rtip_pkg::PH_DONE;
			end else begin
				if (cur.ovf || next_val > limit) begin
					st.ovf = 1'b1;
				end else begin
					st.acc = next_val[31:0];
				end
				st.dig  = 1'b1;
				st.stop = off_next;
			end
		end

		if (st.ovf) begin
			if (signed_mode) begin
				res.value = st.neg ? rtip_pkg::SIGNED_MIN : rtip_pkg::SIGNED_MAX;
			end else begin
				res.value = rtip_pkg::UNSIGNED_MAX;
			end
		end else begin
			res.value = st.neg ? (~st.acc + 32'd1) : st.acc;
		end
		res.offset = st.dig ? st.stop : '0;
		res.ovf    = st.ovf;
		res.found  = st.dig;

		if (string_end) begin
			nxt     = rtip_pkg::STATE_CLEAR;
			nxt_pos = '0;
		end else begin
			nxt     = st;
			nxt_pos = (pos < POS_W'(MAX_LEN)) ? pos + POS_W'(1) : pos;
		end
	end

endmodule
`default_nettype wire

// ===== design/radix_text_to_integer_parser.sv =====
// Top level of the radix text-to-integer parser: input stage, parse state and result register.
// Output: the final character passes the input register and then the result register.
// Throughput: one character per cycle, set by the combinational multiply-add on the
// parse state; the input register stalls only when a final character meets a full
// result register.
// Reset: arst_n clears the handshake and parse state, base 10 and signed mode.
`default_nettype none
module radix_text_to_integer_parser #(
	parameter int MAX_LEN = rtip_pkg::MAX_LEN_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_axis_tvalid,
	output logic                              s_axis_tready,
	input  wire logic [7:0]                   s_axis_tdata,  // char_code[7:0]
	input  wire logic                         s_axis_tlast,  // string_end
	output logic                              m_axis_tvalid,
	input  wire logic                         m_axis_tready,
	// value_bits[31:0], end_offset[39:32], overflowed[40], found_digits[41], zero[47:42]
	output logic [rtip_pkg::OUT_W-1:0]        m_axis_tdata,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [rtip_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int POS_W = $clog2(MAX_LEN + 1);

	logic                          valid_s1;
	logic [rtip_pkg::CHAR_W-1:0]   char_s1;
	logic                          last_s1;
	logic                          advance;
	logic [rtip_pkg::RADIX_W-1:0]  radix_q;
	logic                          signed_q;
	rtip_pkg::state_t              state_q;
	rtip_pkg::state_t              state_nxt;
	logic [POS_W-1:0]              pos_q;
	logic [POS_W-1:0]              pos_nxt;
	rtip_pkg::result_t             res;
	logic                          m_valid_q;
	logic [rtip_pkg::OUT_W-1:0]    m_data_q;

	assign advance       = valid_s1 && (!last_s1 || !m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	rtip_step #(
		.MAX_LEN(MAX_LEN),
		.POS_W  (POS_W)
	) u_step (
		.cur         (state_q),
		.pos         (pos_q),
		.char_code   (char_s1),
		.string_end  (last_s1),
		.radix_select(radix_q),
		.signed_mode (signed_q),
		.nxt         (state_nxt),
		.nxt_pos     (pos_nxt),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q  <= rtip_pkg::RADIX_RESET;
			signed_q <= rtip_pkg::SIGNED_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rtip_pkg::CFG_RADIX:  radix_q  <= cfg_wdata;
				rtip_pkg::CFG_SIGNED: signed_q <= cfg_wdata[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtip_pkg::STATE_CLEAR;
			pos_q   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			pos_q   <= pos_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			m_data_q <= {6'd0, res.found, res.ovf, res.offset, res.value};
		end
	end

	a_offset_needs_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[41] |-> m_axis_tdata[39:32] == 8'd0)
		else $error("end offset without digits");

	a_ovf_needs_digits: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tdata[41])
		else $error("overflow without digits");

	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && m_valid_q && !m_axis_tready |=> valid_s1 && last_s1)
		else $error("final character lost while result stalled");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.phase == rtip_pkg::PH_SKIP && pos_q == '0)
		else $error("parse state not cleared after final character");

endmodule
`default_nettype wire
